>>> rtl/bmu_pkg.sv
`timescale 1ns / 1ps

package bmu_pkg;

  localparam int GRID_SIZE_DEF   = 256;
  localparam int MAX_OUT_DIM_DEF = 4096;

  localparam int STEP_W     = 25;
  localparam int IDX_W      = 16;
  localparam int VAL_W      = 16;
  localparam int PIX_W      = 12;
  localparam int MATTE_W    = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 25;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_X_STEP = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_STEP = 1'b1;

  localparam logic [STEP_W-1:0] STEP_RESET = 25'd65536;

  typedef struct packed {
    logic                     opcode;
    logic [IDX_W-1:0]         load_index;
    logic signed [VAL_W-1:0]  load_value;
    logic [PIX_W-1:0]         pixel_x;
    logic [PIX_W-1:0]         pixel_y;
  } in_item_t;

  typedef struct packed {
    logic [MATTE_W-1:0] matte_value;
  } out_item_t;

endpackage

>>> rtl/bmu_stream_if.sv
`timescale 1ns / 1ps

interface bmu_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/bilinear_matte_upscaler_unit.sv
`timescale 1ns / 1ps

// Bilinear matte upscaler. Load items (opcode 0) write one Q2.14 confidence value into a
// GRID_SIZE x GRID_SIZE grid and return no result; sample items (opcode 1) return one
// matte byte, bilinearly interpolated at the half-pixel-aligned grid position of the
// output pixel. The block takes one item per clock as long as results are taken, and
// bubbles in the pipeline are squeezed out while the output waits. The grid lives in four
// single-port-read RAM banks split by row and column parity, so the four neighbors of a
// sample come from four different banks in one read cycle; that one read per bank per
// cycle sets the rate. Loads write the banks at the same pipeline point where samples
// read them, so a sample sees every load accepted before it. The grid is not cleared
// after reset: samples that touch entries never loaded return undefined values. x_step
// and y_step may only be written while the block is idle.
module bilinear_matte_upscaler_unit #(
  parameter int GRID_SIZE   = bmu_pkg::GRID_SIZE_DEF,
  parameter int MAX_OUT_DIM = bmu_pkg::MAX_OUT_DIM_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  bmu_stream_if.sink                      in_chan,
  bmu_stream_if.source                    out_chan,
  input  logic                            cfg_we,
  input  logic [bmu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bmu_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int RW         = $clog2(GRID_SIZE);
  localparam int HALF       = (GRID_SIZE + 1) / 2;
  localparam int BANK_DEPTH = HALF * HALF;
  localparam int BAW        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int ENTRIES    = GRID_SIZE * GRID_SIZE;
  localparam int RECIP_SH   = 26;
  localparam int RECIP_W    = 26;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SH) / GRID_SIZE);
  localparam int IPROD_W    = bmu_pkg::IDX_W + RECIP_W;
  localparam int TPROD_W    = bmu_pkg::PIX_W + 1 + bmu_pkg::STEP_W;
  localparam int IPW        = TPROD_W - 17;
  localparam int VW         = bmu_pkg::VAL_W;

  typedef struct packed {
    logic [RW-1:0] i0;
    logic [RW-1:0] i1;
    logic [15:0]   w;
  } axis_t;

  function automatic axis_t map_axis(input logic [TPROD_W-1:0] prod);
    logic [TPROD_W-1:0] t;
    logic [TPROD_W-2:0] pos;
    logic [IPW-1:0]     ip;
    axis_t              a;
    t = prod - TPROD_W'(65536);
    if (prod < TPROD_W'(65536)) begin
      pos = '0;
    end else begin
      pos = t[TPROD_W-1:1];
    end
    ip = pos[TPROD_W-2:16];
    if (ip > IPW'(GRID_SIZE - 1)) begin
      a.i0 = RW'(GRID_SIZE - 1);
    end else begin
      a.i0 = ip[RW-1:0];
    end
    a.i1 = (a.i0 == RW'(GRID_SIZE - 1)) ? a.i0 : a.i0 + 1'b1;
    a.w  = pos[15:0];
    return a;
  endfunction

  // Each bank holds every other row and every other column.
  function automatic logic [BAW-1:0] bank_addr(input logic [RW-1:0] row,
                                               input logic [RW-1:0] col);
    return BAW'(((32'(row) >> 1) * HALF) + (32'(col) >> 1));
  endfunction

  function automatic logic [bmu_pkg::PIX_W-1:0] sat_coord(
      input logic [bmu_pkg::PIX_W-1:0] c);
    return (32'(c) >= MAX_OUT_DIM) ? bmu_pkg::PIX_W'(MAX_OUT_DIM - 1) : c;
  endfunction

  // Configuration.
  logic [bmu_pkg::STEP_W-1:0] x_step_r;
  logic [bmu_pkg::STEP_W-1:0] y_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_step_r <= bmu_pkg::STEP_RESET;
      y_step_r <= bmu_pkg::STEP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bmu_pkg::CFG_X_STEP: x_step_r <= cfg_data;
        bmu_pkg::CFG_Y_STEP: y_step_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake chain; a stage takes a new item when it is empty or its item moves on.
  logic v1_r, v2_r, v3_r, v4_r, v5_r, out_valid_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy_out;
  logic s2_op_r;

  assign rdy_out = !out_valid_r || out_chan.ready;
  assign rdy5    = !v5_r || rdy_out;
  assign rdy4    = !v4_r || rdy5;
  assign rdy3    = !v3_r || rdy4;
  assign rdy2    = !v2_r || (s2_op_r == bmu_pkg::OP_LOAD) || rdy3;
  assign rdy1    = !v1_r || rdy2;
  assign in_chan.ready = rdy1;

  logic accept;
  assign accept = in_chan.valid && rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1)    v1_r        <= in_chan.valid;
      if (rdy2)    v2_r        <= v1_r;
      if (rdy3)    v3_r        <= v2_r && (s2_op_r == bmu_pkg::OP_SAMPLE);
      if (rdy4)    v4_r        <= v3_r;
      if (rdy5)    v5_r        <= v4_r;
      if (rdy_out) out_valid_r <= v5_r;
    end
  end

  // Stage 1: position products and the reciprocal product for the load index.
  logic                         s1_op_r;
  logic [TPROD_W-1:0]           s1_prodx_r, s1_prody_r;
  logic [IPROD_W-1:0]           s1_prodi_r;
  logic [bmu_pkg::IDX_W-1:0]    s1_idx_r;
  logic [VW-1:0]                s1_val_r;
  logic [TPROD_W-1:0]           s1_prodx_nxt, s1_prody_nxt;
  logic [IPROD_W-1:0]           s1_prodi_nxt;

  always_comb begin
    s1_prodx_nxt = {sat_coord(in_chan.payload.pixel_x), 1'b1} * x_step_r;
    s1_prody_nxt = {sat_coord(in_chan.payload.pixel_y), 1'b1} * y_step_r;
    s1_prodi_nxt = in_chan.payload.load_index * RECIP;
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_op_r    <= in_chan.payload.opcode;
      s1_prodx_r <= s1_prodx_nxt;
      s1_prody_r <= s1_prody_nxt;
      s1_prodi_r <= s1_prodi_nxt;
      s1_idx_r   <= in_chan.payload.load_index;
      s1_val_r   <= in_chan.payload.load_value;
    end
  end

  // Stage 2: grid indices, weights and bank addresses.
  logic                  s2_inside_r;
  logic [1:0]            s2_wbank_r;
  logic [BAW-1:0]        s2_waddr_r;
  logic [VW-1:0]         s2_wdata_r;
  logic [3:0][BAW-1:0]   s2_raddr_r;
  logic                  s2_y0p_r, s2_y1p_r, s2_x0p_r, s2_x1p_r;
  logic [15:0]           s2_wx_r, s2_wy_r;

  axis_t                 ax_nxt, ay_nxt;
  logic [3:0][BAW-1:0]   s2_raddr_nxt;
  logic [bmu_pkg::IDX_W-1:0] q_apx;
  logic [31:0]           rem_apx;
  logic [31:0]           q_fix, r_fix;
  logic                  s2_inside_nxt;
  logic [RW-1:0]         lrow, lcol;
  logic [BAW-1:0]        s2_waddr_nxt;

  always_comb begin
    ax_nxt = map_axis(s1_prodx_r);
    ay_nxt = map_axis(s1_prody_r);
    for (int b = 0; b < 4; b++) begin
      s2_raddr_nxt[b] = bank_addr((ay_nxt.i0[0] == b[1]) ? ay_nxt.i0 : ay_nxt.i1,
                                  (ax_nxt.i0[0] == b[0]) ? ax_nxt.i0 : ax_nxt.i1);
    end
    // The reciprocal quotient is low by at most one.
    q_apx   = s1_prodi_r[RECIP_SH +: bmu_pkg::IDX_W];
    rem_apx = 32'(s1_idx_r) - 32'(q_apx) * GRID_SIZE;
    if (rem_apx >= 32'(GRID_SIZE)) begin
      q_fix = 32'(q_apx) + 32'd1;
      r_fix = rem_apx - 32'(GRID_SIZE);
    end else begin
      q_fix = 32'(q_apx);
      r_fix = rem_apx;
    end
    s2_inside_nxt = 32'(s1_idx_r) < ENTRIES;
    lrow          = q_fix[RW-1:0];
    lcol          = r_fix[RW-1:0];
    s2_waddr_nxt  = bank_addr(lrow, lcol);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_op_r <= bmu_pkg::OP_LOAD;
    end else if (rdy2) begin
      s2_op_r <= s1_op_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_inside_r <= s2_inside_nxt;
      s2_wbank_r  <= {lrow[0], lcol[0]};
      s2_waddr_r  <= s2_waddr_nxt;
      s2_wdata_r  <= s1_val_r;
      s2_raddr_r  <= s2_raddr_nxt;
      s2_y0p_r    <= ay_nxt.i0[0];
      s2_y1p_r    <= ay_nxt.i1[0];
      s2_x0p_r    <= ax_nxt.i0[0];
      s2_x1p_r    <= ax_nxt.i1[0];
      s2_wx_r     <= ax_nxt.w;
      s2_wy_r     <= ay_nxt.w;
    end
  end

  // Grid banks: loads write and samples read as the item leaves stage 2.
  logic [3:0][VW-1:0] bank_rdata;
  logic [3:0]         bank_we;

  for (genvar b = 0; b < 4; b++) begin : g_bank
    assign bank_we[b] = v2_r && (s2_op_r == bmu_pkg::OP_LOAD) && s2_inside_r
                        && (s2_wbank_r == 2'(b));
    bmu_ram #(
      .WIDTH (VW),
      .DEPTH (BANK_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (bank_we[b]),
      .waddr (s2_waddr_r),
      .wdata (s2_wdata_r),
      .re    (rdy3),
      .raddr (s2_raddr_r[b]),
      .rdata (bank_rdata[b])
    );
  end

  // Stage 3: neighbors arrive, horizontal products.
  logic        s3_y0p_r, s3_y1p_r, s3_x0p_r, s3_x1p_r;
  logic [15:0] s3_wx_r, s3_wy_r;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_y0p_r <= s2_y0p_r;
      s3_y1p_r <= s2_y1p_r;
      s3_x0p_r <= s2_x0p_r;
      s3_x1p_r <= s2_x1p_r;
      s3_wx_r  <= s2_wx_r;
      s3_wy_r  <= s2_wy_r;
    end
  end

  logic signed [VW-1:0] p00, p10, p01, p11;
  logic signed [VW:0]   d_top, d_bot;
  logic signed [33:0]   s4_prodt_nxt, s4_prodb_nxt;

  always_comb begin
    p00 = $signed(bank_rdata[{s3_y0p_r, s3_x0p_r}]);
    p10 = $signed(bank_rdata[{s3_y0p_r, s3_x1p_r}]);
    p01 = $signed(bank_rdata[{s3_y1p_r, s3_x0p_r}]);
    p11 = $signed(bank_rdata[{s3_y1p_r, s3_x1p_r}]);
    d_top = 17'(p10) - 17'(p00);
    d_bot = 17'(p11) - 17'(p01);
    s4_prodt_nxt = d_top * $signed({1'b0, s3_wx_r});
    s4_prodb_nxt = d_bot * $signed({1'b0, s3_wx_r});
  end

  // Stage 4: horizontal results, vertical product.
  logic signed [33:0]   s4_prodt_r, s4_prodb_r;
  logic signed [VW-1:0] s4_p00_r, s4_p01_r;
  logic [15:0]          s4_wy_r;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_prodt_r <= s4_prodt_nxt;
      s4_prodb_r <= s4_prodb_nxt;
      s4_p00_r   <= p00;
      s4_p01_r   <= p01;
      s4_wy_r    <= s3_wy_r;
    end
  end

  logic signed [17:0]  top_full, bot_full;
  logic signed [VW:0]  d_vert;
  logic signed [33:0]  s5_prodv_nxt;

  always_comb begin
    // Arithmetic right shift is the floor of the division by 65536.
    top_full     = 18'(s4_p00_r) + $signed(s4_prodt_r[33:16]);
    bot_full     = 18'(s4_p01_r) + $signed(s4_prodb_r[33:16]);
    d_vert       = 17'(bot_full) - 17'(top_full);
    s5_prodv_nxt = d_vert * $signed({1'b0, s4_wy_r});
  end

  // Stage 5: final value, clamp and byte scaling.
  logic signed [VW-1:0] s5_top_r;
  logic signed [33:0]   s5_prodv_r;

  always_ff @(posedge clk) begin
    if (rdy5) begin
      s5_top_r   <= VW'(top_full);
      s5_prodv_r <= s5_prodv_nxt;
    end
  end

  logic signed [17:0] v_full;
  logic [14:0]        v_clamp;
  logic [22:0]        scaled;
  logic [bmu_pkg::MATTE_W-1:0] matte_nxt;

  always_comb begin
    v_full = 18'(s5_top_r) + $signed(s5_prodv_r[33:16]);
    if (v_full < 18'sd0) begin
      v_clamp = '0;
    end else if (v_full > 18'sd16384) begin
      v_clamp = 15'd16384;
    end else begin
      v_clamp = v_full[14:0];
    end
    scaled    = ({v_clamp, 8'b0} - 23'(v_clamp)) + 23'd8192;
    matte_nxt = scaled[21:14];
  end

  logic [bmu_pkg::MATTE_W-1:0] out_matte_r;

  always_ff @(posedge clk) begin
    if (rdy_out) begin
      out_matte_r <= matte_nxt;
    end
  end

  assign out_chan.valid               = out_valid_r;
  assign out_chan.payload.matte_value = out_matte_r;

  // A load leaving stage 2 never turns into a pending result.
  assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && (s2_op_r == bmu_pkg::OP_LOAD) && rdy3) |=> !v3_r)
    else $error("load item entered the interpolation stages");

  // Neighbor data must hold while stage 3 is stalled.
  assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !rdy4) |=> (bank_rdata === $past(bank_rdata)))
    else $error("bank read data changed under a stalled sample");

  // Loads and samples never use the banks in the same cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (|bank_we) |-> ($onehot(bank_we) && !(v2_r && (s2_op_r == bmu_pkg::OP_SAMPLE))))
    else $error("bank write collides with a sample read");

  // Reset leaves no result pending and the steps at their defaults.
  assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && (x_step_r == bmu_pkg::STEP_RESET)
               && (y_step_r == bmu_pkg::STEP_RESET)))
    else $error("state not cleared by reset");

endmodule

>>> rtl/bmu_ram.sv
`timescale 1ns / 1ps

module bmu_ram #(
  parameter int WIDTH = bmu_pkg::VAL_W,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
